[src/liq_pkg.sv]
// Package with payload types, widths and type-range helpers for the quantizer.
`timescale 1ns / 1ps
package liq_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned StepW   = 63;
  localparam int unsigned TypeW   = 3;
  localparam int unsigned CfgIdxW = 2;
  // prep stage, one stage per quotient bit, rounding stage, output stage
  localparam int unsigned DivStages = DataW;
  localparam int unsigned NumStages = DivStages + 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_TYPE  = 2'd0,
    CFG_STEP_SIZE    = 2'd1,
    CFG_VALUE_MODE   = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DataW-1:0] sample_bits;
    logic             is_last;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] result_bits;
    logic             last_out;
  } out_t;

  // Per-stage pipeline payload
  typedef struct packed {
    logic [DataW-1:0] raw;
    logic [DataW-1:0] mag;
    logic [StepW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW:0]   val;
    logic [DataW-1:0] res;
    logic             neg;
    logic             last;
  } pipe_t;

  // Mask of the type width: 8, 16, 32 or 64 bits
  function automatic logic [DataW-1:0] width_mask(input logic [1:0] wsel);
    logic [DataW-1:0] m;
    case (wsel)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

[src/linear_integer_quantizer.sv]
// Pipelined uniform integer quantizer, round half away from zero.
//
//  channel | direction | signals
//  in      | input     | in_valid_i, in_stall_o, in_data_i (sample_bits, is_last)
//  out     | output    | out_valid_o, out_stall_i, out_data_o (result_bits, last_out)
//  cfg     | input     | cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle sustained while the output is not stalled; the pipe is a prep stage,
// 64 restoring-division stages (one quotient bit each against the step),
// a rounding stage and the output register.
// Reset clears all valid bits and the configuration registers.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up while the output is stalled; nothing is lost or repeated.
`timescale 1ns / 1ps
module linear_integer_quantizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  liq_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output liq_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [liq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [liq_pkg::StepW-1:0]     cfg_wdata_i
);
  import liq_pkg::*;

  localparam int unsigned LastSt  = NumStages - 1;
  localparam int unsigned RoundSt = NumStages - 2;

  logic [TypeW-1:0] type_q;
  logic [StepW-1:0] step_q;
  logic             store_q;
  logic [StepW-1:0] half_up_q;

  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   adv;
  pipe_t                p_q [NumStages];
  pipe_t                p_d [NumStages];

  logic [DataW-1:0] mask;
  logic [DataW-1:0] hi;
  logic             is_signed;
  logic             pass;

  assign mask      = width_mask(type_q[1:0]);
  assign hi        = mask >> 1;
  assign is_signed = type_q[2];
  assign pass      = (step_q == '0);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q    <= '0;
      step_q    <= '0;
      store_q   <= 1'b0;
      half_up_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SAMPLE_TYPE:  type_q  <= cfg_wdata_i[TypeW-1:0];
          CFG_STEP_SIZE:    step_q  <= cfg_wdata_i;
          CFG_VALUE_MODE:   store_q <= cfg_wdata_i[0];
          default:          ;
        endcase
      end
      // ceil(step/2): remainder at or above it rounds up
      half_up_q <= step_q - (step_q >> 1);
    end
  end

  // Advance chain from the output back to the input
  always_comb begin
    adv[NumStages] = !out_stall_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];

  // Stage logic
  always_comb begin
    logic [DataW-1:0] raw;
    logic [DataW:0]   t;
    logic             carry;
    logic [DataW:0]   lim;
    logic [DataW:0]   r;
    pipe_t            s;
    p_d[0] = '0;
    for (int k = 1; k < NumStages; k++) begin
      p_d[k] = p_q[k-1];
    end

    // prep: take magnitude and sign of the sample
    raw           = in_data_i.sample_bits & mask;
    p_d[0].raw    = raw;
    p_d[0].neg    = is_signed && ((raw & ((mask >> 1) + 64'd1)) != '0);
    p_d[0].mag    = p_d[0].neg ? ((64'd0 - raw) & mask) : raw;
    p_d[0].quo    = p_d[0].mag;
    p_d[0].rem    = '0;
    p_d[0].val    = '0;
    p_d[0].res    = '0;
    p_d[0].last   = in_data_i.is_last;

    // restoring division, one quotient bit per stage
    for (int k = 1; k <= DivStages; k++) begin
      s = p_q[k-1];
      t = {1'b0, s.rem, s.quo[DataW-1]};
      if (t >= {2'b00, step_q}) begin
        t = t - {2'b00, step_q};
        p_d[k].quo = {s.quo[DataW-2:0], 1'b1};
      end else begin
        p_d[k].quo = {s.quo[DataW-2:0], 1'b0};
      end
      p_d[k].rem = t[StepW-1:0];
    end

    // round: q += carry, q*step = mag - rem + carry*step
    s     = p_q[RoundSt-1];
    carry = (s.rem >= half_up_q);
    p_d[RoundSt].quo = s.quo + {{(DataW-1){1'b0}}, carry};
    p_d[RoundSt].val = {1'b0, s.mag} - {2'b00, s.rem}
                     + (carry ? {2'b00, step_q} : '0);

    // zero step passes the raw sample; else restore sign and mask the quotient, or saturate the value to the type range
    s   = p_q[LastSt-1];
    lim = {1'b0, hi} + 65'd1;
    r   = s.val;
    if (pass) begin
      p_d[LastSt].res = s.raw;
    end else if (!store_q) begin
      p_d[LastSt].res = (s.neg ? (64'd0 - s.quo) : s.quo) & mask;
    end else if (!is_signed) begin
      p_d[LastSt].res = (r > {1'b0, mask}) ? mask : r[DataW-1:0];
    end else if (s.neg) begin
      if (r > lim) begin
        r = lim;
      end
      p_d[LastSt].res = (64'd0 - r[DataW-1:0]) & mask;
    end else begin
      p_d[LastSt].res = (r > {1'b0, hi}) ? hi : r[DataW-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Payload registers: hold while the stage is blocked
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (adv[k]) begin
        p_q[k] <= p_d[k];
      end
    end
  end

  assign out_valid_o            = v_q[LastSt];
  assign out_data_o.result_bits = p_q[LastSt].res;
  assign out_data_o.last_out    = p_q[LastSt].last;

  // Input is held back only when the whole pipe is full and the output blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled with a free stage");

  // Result never carries bits above the type width
  a_res_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.result_bits & ~mask) == '0))
    else $error("result has bits above the type width");

  // Pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> (v_q == '0))
    else $error("valid bits set after reset");

endmodule
